// ===== hdl/gbr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 Gaussian blur.
package gbr_pkg;

   localparam int GBR_MAX_WIDTH = 2048;

   localparam int KERNEL_SIZE = 3;
   localparam logic [2:0] KERNEL_WEIGHT [KERNEL_SIZE][KERNEL_SIZE] = '{
      '{3'd1, 3'd2, 3'd1},
      '{3'd2, 3'd4, 3'd2},
      '{3'd1, 3'd2, 3'd1}
   };
   // kernel sum is 16: round by adding half of it, then shift
   localparam int          KERNEL_SHIFT = 4;
   localparam int          KERNEL_ACC_W = 12;
   localparam logic [11:0] KERNEL_ROUND = 12'd8;

   localparam int          IMG_WIDTH_W    = 12;
   localparam int          IMG_HEIGHT_W   = 15;
   localparam logic [11:0] IMG_WIDTH_RST  = 12'd640;
   localparam logic [14:0] IMG_HEIGHT_RST = 15'd480;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_BIT = 2;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef logic [7:0] chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } line_pair_type;

endpackage

// ===== hdl/gbr_req_if.sv =====
`timescale 1ns / 1ps
// Pixel input channel of the blur.
interface gbr_req_if
   import gbr_pkg::*;
();
   logic     valid;
   logic     ready;
   chan_type blue_in;
   chan_type green_in;
   chan_type red_in;
   logic     flush;

   modport source (output valid, output blue_in, output green_in, output red_in,
                   output flush, input ready);
   modport sink   (input valid, input blue_in, input green_in, input red_in,
                   input flush, output ready);
endinterface

// ===== hdl/gbr_rsp_if.sv =====
`timescale 1ns / 1ps
// Pixel result channel of the blur.
interface gbr_rsp_if
   import gbr_pkg::*;
();
   logic     valid;
   logic     ready;
   chan_type blue_out;
   chan_type green_out;
   chan_type red_out;
   logic     frame_last;

   modport source (output valid, output blue_out, output green_out, output red_out,
                   output frame_last, input ready);
   modport sink   (input valid, input blue_out, input green_out, input red_out,
                   input frame_last, output ready);
endinterface

// ===== hdl/gbr_line_mem.sv =====
`timescale 1ns / 1ps
// Two-row line memory with clearing pass after reset and write-to-read forwarding.
module gbr_line_mem
   import gbr_pkg::*;
#(
   parameter int MAX_WIDTH = GBR_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output line_pair_type                rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  line_pair_type                wr_data,
   output logic                         clearing
);

   localparam int             AW        = $clog2(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

   line_pair_type mem [MAX_WIDTH];
   line_pair_type q_ff;
   line_pair_type fwd_data_ff;
   logic          fwd_ff;
   logic          clear_ff, clear_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         fwd_ff        <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         // a read that meets a write to the same entry sees the old word: take the new one
         fwd_ff        <= rd_en && wr_en && (rd_addr == wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = fwd_ff ? fwd_data_ff : q_ff;
   assign clearing = clear_ff;

endmodule

// ===== hdl/gaussian_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// Top level: 3x3 Gaussian blur of an RGB pixel stream in raster order.
//
// Pixels enter on req_ch (valid/ready), one per transfer, and results leave on
// rsp_ch. Each channel is filtered by [1 2 1; 2 4 2; 1 2 1] and rounded; the
// border rows and columns pass through. A result belongs to the pixel width+1
// transfers earlier; after a frame, width+1 flush transfers drain the rest.
// image_width (byte address 0) and image_height (byte address 4) are written over
// the APB port only while the block is idle, a rule on the user that the block does
// not enforce; a write restarts the frame position. Throughput: one pixel per clock
// while ready is high, set by the line memory, which does one read and one write in
// the same cycle. Results pass the memory and window stages to a queue on rsp_ch.
// Reset: the line memory is swept to zero, one column per clock, so ready stays
// low until the sweep has passed the last column; the APB port is usable throughout.
// Stall: results queue in a 4-entry buffer. The input keeps flowing while the
// receiver stalls and, outside the reset sweep, ready drops only when the queue and
// the two stages in flight could not take another result.
module gaussian_blur_3x3_rgb
   import gbr_pkg::*;
#(
   parameter int MAX_WIDTH = GBR_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   gbr_req_if.sink               req_ch,
   gbr_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = WW + 1;
   localparam int RW = IMG_HEIGHT_W + 1;

   typedef pixel_type win_type [KERNEL_SIZE][KERNEL_SIZE];

   typedef struct packed {
      logic emit;
      logic blur;
      logic last;
   } res_ctl_type;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } res_type;

   function automatic chan_type blur_chan(input win_type win, input int ch);
      logic [KERNEL_ACC_W-1:0] acc;
      acc = KERNEL_ROUND;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            acc = acc + KERNEL_ACC_W'(KERNEL_WEIGHT[r][c]) * KERNEL_ACC_W'(win[r][c][8*ch +: 8]);
         end
      end
      return acc[KERNEL_SHIFT +: 8];
   endfunction

   // configuration
   logic [IMG_WIDTH_W-1:0]  image_width_ff, width_in;
   logic [IMG_HEIGHT_W-1:0] image_height_ff, height_in;
   logic                    csr_wr;
   csr_reg_type             csr_sel;

   // frame position
   logic [AW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [AW-1:0] c_in_col, c_out_col;
   logic [RW-1:0] c_in_row, c_out_row;
   logic [WW-1:0] eff_w;
   logic [RW-1:0] eff_h;

   logic          acc_xfer, act, act_acc, restart;
   pixel_type     pix_in;
   res_ctl_type   ctl;

   // memory stage
   logic          s1_v_ff;
   logic [AW-1:0] s1_addr_ff;
   pixel_type     s1_pix_ff;
   res_ctl_type   s1_ctl_ff;
   line_pair_type line_rd, line_wr;
   logic          clearing;

   // window stage
   win_type       win_ff;
   logic          s2_v_ff, s2_blur_ff, s2_last_ff;
   res_type       res_d;

   // result queue
   res_type              fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 push, pop;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = csr_reg_type'(paddr[CSR_IDX_BIT]);

   always_comb begin
      width_in  = image_width_ff;
      height_in = image_height_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            REG_IMAGE_WIDTH:  width_in  = pwdata[IMG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[IMG_HEIGHT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_IMAGE_WIDTH:  prdata = 32'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = 32'(image_height_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMG_WIDTH_RST;
         image_height_ff <= IMG_HEIGHT_RST;
      end else begin
         image_width_ff  <= width_in;
         image_height_ff <= height_in;
      end
   end

   // clamp the width to what the line memory holds; a zero width or height counts as one
   always_comb begin
      if (image_width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(image_width_ff);
      end
      eff_h = (image_height_ff == '0) ? RW'(1) : RW'(image_height_ff);
   end

   // ---------------- intake and frame position ----------------
   assign acc_xfer = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !clearing &&
      ((RSP_CNT_W'(cnt_ff) + RSP_CNT_W'(s1_v_ff) + RSP_CNT_W'(s2_v_ff)) <
       RSP_CNT_W'(RSP_DEPTH));

   always_comb begin
      act     = 1'b0;
      restart = 1'b0;
      pix_in  = '{red: req_ch.red_in, green: req_ch.green_in, blue: req_ch.blue_in};
      if (in_row_ff < eff_h) begin
         act = !req_ch.flush;
      end else if (out_row_ff >= eff_h) begin
         // frame fully delivered: a pixel opens the next one, a flush is dropped
         act     = !req_ch.flush;
         restart = !req_ch.flush;
      end else begin
         // draining: any transfer pushes a blank pixel through
         act    = 1'b1;
         pix_in = '0;
      end
      act_acc = acc_xfer && act;

      c_in_col  = restart ? '0 : in_col_ff;
      c_in_row  = restart ? '0 : in_row_ff;
      c_out_col = restart ? '0 : out_col_ff;
      c_out_row = restart ? '0 : out_row_ff;

      ctl.emit = (c_in_row > RW'(1)) || ((c_in_row == RW'(1)) && (c_in_col != '0));
      ctl.blur = (c_out_row != '0) && ((c_out_row + RW'(2)) <= eff_h) &&
                 (c_out_col != '0) && ((CW'(c_out_col) + CW'(2)) <= CW'(eff_w));
      ctl.last = ((c_out_row + RW'(1)) == eff_h) && ((WW'(c_out_col) + WW'(1)) == eff_w);

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (act_acc) begin
         if ((WW'(c_in_col) + WW'(1)) >= eff_w) begin
            in_col_in = '0;
            in_row_in = c_in_row + RW'(1);
         end else begin
            in_col_in = c_in_col + AW'(1);
            in_row_in = c_in_row;
         end
         out_col_in = c_out_col;
         out_row_in = c_out_row;
         if (ctl.emit) begin
            if ((WW'(c_out_col) + WW'(1)) >= eff_w) begin
               out_col_in = '0;
               out_row_in = c_out_row + RW'(1);
            end else begin
               out_col_in = c_out_col + AW'(1);
            end
         end
      end
      if (csr_wr) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_v_ff    <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         s1_v_ff    <= act_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (act_acc) begin
         s1_addr_ff <= c_in_col;
         s1_pix_ff  <= pix_in;
         s1_ctl_ff  <= ctl;
      end
   end

   // ---------------- line memory ----------------
   assign line_wr = '{upper: line_rd.lower, lower: s1_pix_ff};

   gbr_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (act_acc),
      .rd_addr  (c_in_col),
      .rd_data  (line_rd),
      .wr_en    (s1_v_ff),
      .wr_addr  (s1_addr_ff),
      .wr_data  (line_wr),
      .clearing (clearing)
   );

   // ---------------- window ----------------
   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
               win_ff[r][c] <= win_ff[r][c+1];
            end
         end
         win_ff[0][KERNEL_SIZE-1] <= line_rd.upper;
         win_ff[1][KERNEL_SIZE-1] <= line_rd.lower;
         win_ff[2][KERNEL_SIZE-1] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff && s1_ctl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      s2_blur_ff <= s1_ctl_ff.blur;
      s2_last_ff <= s1_ctl_ff.last;
   end

   always_comb begin
      if (s2_blur_ff) begin
         res_d.pix.blue  = blur_chan(win_ff, 0);
         res_d.pix.green = blur_chan(win_ff, 1);
         res_d.pix.red   = blur_chan(win_ff, 2);
      end else begin
         res_d.pix = win_ff[1][1];
      end
      res_d.last = s2_last_ff;
   end

   // ---------------- result queue ----------------
   assign push = s2_v_ff;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      cnt_in = cnt_ff;
      priority if (push && !pop) begin
         cnt_in = cnt_ff + RSP_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - RSP_CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res_d;
      end
   end

   assign rsp_ch.valid      = (cnt_ff != '0);
   assign rsp_ch.blue_out   = fifo_ff[rd_ptr_ff].pix.blue;
   assign rsp_ch.green_out  = fifo_ff[rd_ptr_ff].pix.green;
   assign rsp_ch.red_out    = fifo_ff[rd_ptr_ff].pix.red;
   assign rsp_ch.frame_last = fifo_ff[rd_ptr_ff].last;

   // ---------------- checks ----------------
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (cnt_ff < RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue overflow");

   a_window_follows_memory: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> $past(s1_v_ff))
      else $error("window stage valid without a memory stage item");

   a_result_from_window: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(s2_v_ff))
      else $error("result appeared without a transfer from the window stage");

endmodule

// ===== tb/gbr_tb_pkg.sv =====
`timescale 1ns / 1ps
// Expected-pixel tracker for the 3x3 Gaussian blur testbench.
package gbr_tb_pkg;
   import gbr_pkg::*;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } blur_out_type;

   class blur_predictor;
      pixel_type    upper_line [GBR_MAX_WIDTH];
      pixel_type    lower_line [GBR_MAX_WIDTH];
      pixel_type    window [3][3];
      int unsigned  width_reg;
      int unsigned  height_reg;
      int unsigned  in_col;
      int unsigned  in_row;
      int unsigned  out_col;
      int unsigned  out_row;
      blur_out_type owed_pixels [$];
      int unsigned  mismatches;
      int unsigned  matched;
      int unsigned  arrived;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
         end
         foreach (window[r, c]) window[r][c] = '0;
         width_reg  = 32'(IMG_WIDTH_RST);
         height_reg = 32'(IMG_HEIGHT_RST);
         mismatches = 0;
         matched    = 0;
         arrived    = 0;
         restart();
      endfunction

      function void restart();
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > GBR_MAX_WIDTH) return GBR_MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function void write_register(csr_reg_type idx, logic [31:0] value);
         if (idx == REG_IMAGE_WIDTH) width_reg = 32'(value[IMG_WIDTH_W-1:0]);
         else height_reg = 32'(value[IMG_HEIGHT_W-1:0]);
         restart();
      endfunction

      function logic [31:0] register_value(csr_reg_type idx);
         return (idx == REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);
      endfunction

      // ch 0 is blue, 1 green, 2 red
      function chan_type blur_channel(int ch);
         int unsigned acc;
         int r;
         int c;
         acc = 8;
         for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
               acc += ((r == 1) ? 2 : 1) * ((c == 1) ? 2 : 1) * window[r][c][8*ch +: 8];
         return chan_type'(acc >> 4);
      endfunction

      // Returns 0 when the block drops the transfer with no effect.
      function bit take_pixel(pixel_type pix, logic flush);
         int unsigned  w;
         int unsigned  h;
         int unsigned  pos;
         int           r;
         pixel_type    up;
         pixel_type    lo;
         blur_out_type res;
         w = eff_width();
         h = eff_height();
         if (in_row < h) begin
            if (flush) return 0;
         end else if (out_row >= h) begin
            if (flush) return 0;
            restart();
         end else begin
            // draining: any transfer counts as a flush
            pix = '0;
         end
         up = upper_line[in_col];
         lo = lower_line[in_col];
         upper_line[in_col] = lo;
         lower_line[in_col] = pix;
         for (r = 0; r < 3; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
         end
         window[0][2] = up;
         window[1][2] = lo;
         window[2][2] = pix;
         pos = in_row * w + in_col;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         if (pos < w + 1) return 1;
         if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w) begin
            res.pix.blue  = blur_channel(0);
            res.pix.green = blur_channel(1);
            res.pix.red   = blur_channel(2);
         end else begin
            res.pix = window[1][1];
         end
         res.last = (out_row + 1 == h && out_col + 1 == w);
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         owed_pixels.push_back(res);
         return 1;
      endfunction

      task report(string msg);
         mismatches++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      task match_result(blur_out_type got);
         blur_out_type want;
         arrived++;
         if (owed_pixels.size() == 0) begin
            report($sformatf("result %0d (%h) arrived with none owed", arrived, got));
            return;
         end
         want = owed_pixels.pop_front();
         if (got.pix.red !== want.pix.red)
            report($sformatf("result %0d red %h, want %h", arrived, got.pix.red, want.pix.red));
         if (got.pix.green !== want.pix.green)
            report($sformatf("result %0d green %h, want %h", arrived, got.pix.green,
                             want.pix.green));
         if (got.pix.blue !== want.pix.blue)
            report($sformatf("result %0d blue %h, want %h", arrived, got.pix.blue,
                             want.pix.blue));
         if (got.last !== want.last)
            report($sformatf("result %0d frame_last %b, want %b", arrived, got.last, want.last));
         if (got === want) matched++;
      endtask
   endclass

endpackage

// ===== tb/tb_gaussian_blur_3x3_rgb.sv =====
`timescale 1ns / 1ps
// Top of the 3x3 Gaussian blur testbench: clock, reset, drivers and checks.
module tb_gaussian_blur_3x3_rgb;
   import gbr_pkg::*;
   import gbr_tb_pkg::*;

   localparam logic [23:0] CHECKER [9] = '{
      24'hFFFFFF, 24'h000000, 24'hFFFFFF,
      24'h000000, 24'h80FF01, 24'h000000,
      24'hFFFFFF, 24'h000000, 24'hFFFFFF
   };
   localparam int unsigned RANDOM_TRANSFERS = 550;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   gbr_req_if req_ch ();
   gbr_rsp_if rsp_ch ();

   blur_predictor sb = new();
   blur_out_type  seen;
   int unsigned   send_idle_pct = 12;
   int unsigned   recv_idle_pct = 64;
   int unsigned   counted = 0;
   int unsigned   frames = 0;

   gaussian_blur_3x3_rgb dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.pix.red   = rsp_ch.red_out;
         seen.pix.green = rsp_ch.green_out;
         seen.pix.blue  = rsp_ch.blue_out;
         seen.last      = rsp_ch.frame_last;
         sb.match_result(seen);
      end
   end

   function automatic pixel_type random_pixel();
      logic [23:0] v;
      v = 24'($urandom);
      return v;
   endfunction

   // Call at a falling edge; returns at the falling edge after the transfer.
   task automatic send_transfer(pixel_type pix, logic flush);
      bit done;
      done = 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.red_in   = pix.red;
      req_ch.green_in = pix.green;
      req_ch.blue_in  = pix.blue;
      req_ch.flush    = flush;
      while (!done) begin
         @(posedge clock);
         done = (req_ch.ready === 1'b1);
         if (done && sb.take_pixel(pix, flush)) counted++;
         @(negedge clock);
      end
   endtask

   // Hold off until every owed pixel is out and the pipeline has settled.
   task automatic wait_quiet();
      req_ch.valid = 1'b0;
      while (sb.owed_pixels.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_access(csr_reg_type idx, logic wr, logic [31:0] value);
      logic [31:0] want;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = '0;
      paddr[CSR_IDX_BIT] = idx;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (wr) begin
         sb.write_register(idx, value);
      end else begin
         want = sb.register_value(idx);
         if (prdata !== want)
            sb.report($sformatf("register %s reads %h, want %h", idx.name(), prdata, want));
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_write(csr_reg_type idx, logic [31:0] value);
      csr_access(idx, 1'b1, value);
      csr_access(idx, 1'b0, '0);
   endtask

   // One well-formed frame with random content, some ignored flushes mixed in
   // and some drain flushes swapped for pixels, which drain just like flushes.
   task automatic send_frame(int unsigned noise_pct, int unsigned swap_pct);
      int unsigned w;
      int unsigned h;
      int unsigned n;
      w = sb.eff_width();
      h = sb.eff_height();
      for (n = 0; n < w * h; n++) begin
         if ($urandom_range(99) < noise_pct) send_transfer(random_pixel(), 1'b1);
         send_transfer(random_pixel(), 1'b0);
      end
      for (n = 0; n <= w; n++)
         send_transfer(random_pixel(), $urandom_range(99) >= swap_pct);
      frames++;
   endtask

   initial begin
      int unsigned start;
      int unsigned done_part;
      int unsigned pick;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned k;
      bit          aborted;

      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_ch.valid    = 1'b0;
      req_ch.red_in   = '0;
      req_ch.green_in = '0;
      req_ch.blue_in  = '0;
      req_ch.flush    = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_access(REG_IMAGE_WIDTH, 1'b0, '0);
      csr_access(REG_IMAGE_HEIGHT, 1'b0, '0);

      // zero width and height act as a single pixel frame
      csr_write(REG_IMAGE_WIDTH, 32'd0);
      csr_write(REG_IMAGE_HEIGHT, 32'd0);
      send_transfer(24'hFFFFFF, 1'b0);
      send_transfer(24'h000000, 1'b1);
      send_transfer(24'h000000, 1'b1);
      // a pixel after the drain opens the next frame
      send_transfer(24'h000000, 1'b0);
      send_transfer(24'h000000, 1'b1);
      send_transfer(24'hA5A5A5, 1'b0);
      send_transfer(24'h5A5A5A, 1'b1);
      frames += 2;

      // upper bits of pwdata are outside the fields
      wait_quiet();
      csr_write(REG_IMAGE_WIDTH, 32'hABCD_E003);
      csr_write(REG_IMAGE_HEIGHT, 32'hFFFF_0003);
      send_transfer(24'hFFFFFF, 1'b1);
      for (k = 0; k < 9; k++) begin
         send_transfer(pixel_type'(CHECKER[k]), 1'b0);
         if (k == 4) send_transfer(24'h000000, 1'b1);
      end
      send_transfer(24'h000000, 1'b1);
      send_transfer(24'hFFFFFF, 1'b0);
      send_transfer(24'h000000, 1'b1);
      send_transfer(24'h000000, 1'b1);
      send_transfer(24'hFFFFFF, 1'b1);
      frames++;

      // field maxima: width clamps to the line length, height never completes
      wait_quiet();
      csr_write(REG_IMAGE_WIDTH, 32'hFFF);
      csr_write(REG_IMAGE_HEIGHT, 32'h7FFF);
      repeat (GBR_MAX_WIDTH + 4) send_transfer(random_pixel(), 1'b0);

      start   = counted;
      aborted = 1'b1;
      while (counted - start < RANDOM_TRANSFERS) begin
         done_part = (counted - start) * 3 / RANDOM_TRANSFERS;
         if (done_part == 0) begin
            send_idle_pct = 12;
            recv_idle_pct = 64;
         end else if (done_part == 1) begin
            send_idle_pct = 64;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(99);
         if (aborted || pick < 50) begin
            k = $urandom_range(99);
            w = (k < 5) ? 0 : (k < 10) ? 1 : (k < 15) ? 2 : $urandom_range(9, 3);
            k = $urandom_range(99);
            h = (k < 5) ? 0 : (k < 10) ? 1 : (k < 15) ? 2 : $urandom_range(7, 3);
            wait_quiet();
            csr_write(REG_IMAGE_WIDTH, w);
            csr_write(REG_IMAGE_HEIGHT, h);
         end
         aborted = 1'b0;
         if (pick >= 90) begin
            // cut the frame short; the next write restarts the position
            n = $urandom_range(sb.eff_width() * sb.eff_height() - 1);
            repeat (n) send_transfer(random_pixel(), 1'b0);
            aborted = 1'b1;
         end else begin
            send_frame(10, 25);
            if ($urandom_range(3) == 0) send_transfer(random_pixel(), 1'b1);
         end
      end

      wait_quiet();
      $display("%0d results matched over %0d frames from %0d pixel transfers",
               sb.matched, frames, counted);
      $display("widths 0 to 4095 and heights 0 to 32767 set, stalls on both sides");
      if (sb.mismatches == 0 && sb.owed_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/gbr_pkg.sv
hdl/gbr_req_if.sv
hdl/gbr_rsp_if.sv
hdl/gbr_line_mem.sv
hdl/gaussian_blur_3x3_rgb.sv
tb/gbr_tb_pkg.sv
tb/tb_gaussian_blur_3x3_rgb.sv
